// ----- rtl/core/tlpf_pkg.sv -----
// Shared constants, codes and types of the page frame manager.
`default_nettype none

package tlpf_pkg;

	// Frame table geometry.
	localparam int MaxFrames = 16;
	localparam int FrameW    = $clog2(MaxFrames);
	localparam int CountW    = $clog2(MaxFrames + 1);
	localparam int RankW     = FrameW;
	localparam int PageW     = 8;
	localparam int FaultW    = 16;

	localparam logic [RankW-1:0]  RankMax  = RankW'(MaxFrames - 1);
	localparam logic [CountW-1:0] CountMax = CountW'(MaxFrames);
	localparam logic [FaultW-1:0] FaultMax = {FaultW{1'b1}};

	// Configuration port.
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = CountW;
	localparam logic [CfgIdxW-1:0] CFG_FRAMES_IN_USE = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_PINNED_COUNT  = 1'b1;

	localparam logic [CountW-1:0] FramesInUseReset = CountW'(16);
	localparam logic [CountW-1:0] PinnedCountReset = '0;

	typedef enum logic [1:0] {
		KIND_REF   = 2'd0,
		KIND_PIN   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OUT_PINNED_HIT = 3'd0,
		OUT_TABLE_HIT  = 3'd1,
		OUT_FREE_FILL  = 3'd2,
		OUT_REPLACED   = 3'd3,
		OUT_NO_FRAME   = 3'd4,
		OUT_SETUP_DONE = 3'd5
	} outcome_t;

	typedef logic [RankW-1:0] rank_t;
	typedef logic [PageW-1:0] page_t;

	typedef struct packed {
		logic              found;
		logic [FrameW-1:0] idx;
	} victim_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlpf_if.sv -----
// Request and response channel interfaces of the page frame manager.
`default_nettype none

interface tlpf_req_if
	import tlpf_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [FrameW-1:0] slot;
	logic [PageW-1:0]  page;

	modport source(output valid, kind, slot, page, input ready);
	modport sink(input valid, kind, slot, page, output ready);
endinterface

interface tlpf_rsp_if
	import tlpf_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [2:0]        outcome;
	logic [FrameW-1:0] frame;
	logic [PageW-1:0]  evicted_page;
	logic              evicted_valid;
	logic [FaultW-1:0] fault_count;

	modport source(output valid, outcome, frame, evicted_page, evicted_valid, fault_count,
		input ready);
	modport sink(input valid, outcome, frame, evicted_page, evicted_valid, fault_count,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tlpf_victim_sel.sv -----
// Least recently used victim pick over the managed frames by pairwise rank compare.
`default_nettype none

module tlpf_victim_sel
	import tlpf_pkg::*;
(
	input  logic [MaxFrames-1:0]        cand,
	input  rank_t [MaxFrames-1:0]       rank,
	output victim_t                     victim
);

	logic [MaxFrames-1:0] win;
	logic [FrameW-1:0]    idx;

	// A candidate wins when it is strictly older than every lower candidate and
	// at least as old as every higher one, so ties go to the lowest frame.
	always_comb begin
		for (int i = 0; i < MaxFrames; i++) begin
			win[i] = cand[i];
			for (int j = 0; j < MaxFrames; j++) begin
				if (j < i) begin
					if (cand[j] && !(rank[i] > rank[j])) win[i] = 1'b0;
				end else if (j > i) begin
					if (cand[j] && !(rank[i] >= rank[j])) win[i] = 1'b0;
				end
			end
		end
	end

	// The winner vector is one-hot, so its index is an OR of indices.
	always_comb begin
		idx = '0;
		for (int i = 0; i < MaxFrames; i++) begin
			if (win[i]) idx = idx | FrameW'(i);
		end
	end

	assign victim.found = |cand;
	assign victim.idx   = idx;

endmodule

`default_nettype wire

// ----- rtl/core/tlpf_lru_page_frame_manager.sv -----
// Top level of the page frame manager with pinned translations and LRU replacement.
`default_nettype none

//  Channel | Dir | Beat contents                                            | Handshake
//  --------+-----+----------------------------------------------------------+-------------
//  req     | in  | kind, slot, page                                         | valid/ready
//  rsp     | out | outcome, frame, evicted_page, evicted_valid, fault_count | valid/ready
//  cfg     | in  | cfg_idx, cfg_wdata (frames_in_use, pinned_count)         | cfg_we only
//
//  One request beat is taken per cycle unless a stalled response holds both registers.
//  A beat lands in the input register, all lookup, victim choice and rank update happen in
//  one combinational pass through the sixteen-entry compare and the rank update, and the
//  result is held in the result register until it is taken.
//  Reset clears the control state, the valid bits, ranks, free pointer and fault count;
//  frame page contents stay undefined until filled. A stalled response holds its
//  register, and the input register drains into it as soon as it is free or taken.

module tlb_lru_page_frame_manager
	import tlpf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	tlpf_req_if.sink                 req,
	tlpf_rsp_if.source               rsp,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_idx,
	input  wire logic [CfgDataW-1:0] cfg_wdata
);

	// Configuration registers.
	logic [CountW-1:0] frames_in_use_q;
	logic [CountW-1:0] pinned_count_q;

	// Translation and frame state.
	page_t [MaxFrames-1:0] pinned_page_q;
	logic  [MaxFrames-1:0] pinned_valid_q;
	page_t [MaxFrames-1:0] frame_page_q;
	logic  [MaxFrames-1:0] frame_valid_q;
	rank_t [MaxFrames-1:0] rank_q;
	logic  [CountW-1:0]    next_free_q;
	logic  [FaultW-1:0]    fault_q;

	// Input register.
	logic              valid_s1;
	kind_t             kind_s1;
	logic [FrameW-1:0] slot_s1;
	page_t             page_s1;

	// Result register.
	logic              valid_s2;
	outcome_t          outcome_s2;
	logic [FrameW-1:0] frame_s2;
	page_t             ev_page_s2;
	logic              ev_valid_s2;

	logic adv;
	logic step;
	logic take;

	// A beat in the input register moves on whenever the result register is free
	// or is being emptied in the same cycle; the state changes at that same edge.
	assign adv       = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FramesInUseReset;
			pinned_count_q  <= PinnedCountReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_wdata;
				CFG_PINNED_COUNT:  pinned_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Register bounds: values above the table depth act as the full depth.
	logic [CountW-1:0] lo;
	logic [CountW-1:0] hi;
	assign lo = (pinned_count_q > CountMax) ? CountMax : pinned_count_q;
	assign hi = (frames_in_use_q > CountMax) ? CountMax : frames_in_use_q;

	// Associative compares against the registered page.
	logic [MaxFrames-1:0] pin_hit;
	logic [MaxFrames-1:0] frm_hit;
	logic [MaxFrames-1:0] cand;
	logic [FrameW-1:0]    pin_idx;
	logic [FrameW-1:0]    frm_idx;

	always_comb begin
		for (int i = 0; i < MaxFrames; i++) begin
			pin_hit[i] = (CountW'(i) < lo) && pinned_valid_q[i] && (pinned_page_q[i] == page_s1);
			cand[i]    = (CountW'(i) >= lo) && (CountW'(i) < hi) && frame_valid_q[i];
			frm_hit[i] = cand[i] && (frame_page_q[i] == page_s1);
		end
	end

	// Lowest matching entry wins in both tables.
	always_comb begin
		pin_idx = '0;
		frm_idx = '0;
		for (int i = MaxFrames - 1; i >= 0; i--) begin
			if (pin_hit[i]) pin_idx = FrameW'(i);
			if (frm_hit[i]) frm_idx = FrameW'(i);
		end
	end

	victim_t victim;

	tlpf_victim_sel u_victim_sel (
		.cand   (cand),
		.rank   (rank_q),
		.victim (victim)
	);

	// The fill position is lifted out of the pinned range when the free pointer lies inside it.
	logic [CountW-1:0] fill;
	logic              fill_ok;
	assign fill    = (next_free_q < lo) ? lo : next_free_q;
	assign fill_ok = fill < hi;

	// Decision for the beat in the input register.
	outcome_t              outcome_d;
	logic [FrameW-1:0]     frame_d;
	page_t                 ev_page_d;
	logic                  ev_valid_d;
	logic                  do_touch;
	logic                  do_insert;
	logic                  do_clear;
	logic                  do_pin;
	logic [FrameW-1:0]     tgt;
	rank_t                 tgt_rank;
	rank_t [MaxFrames-1:0] rank_d;
	logic  [MaxFrames-1:0] frame_valid_d;
	logic  [CountW-1:0]    next_free_d;
	logic  [FaultW-1:0]    fault_d;

	always_comb begin
		outcome_d   = OUT_SETUP_DONE;
		frame_d     = '0;
		ev_page_d   = '0;
		ev_valid_d  = 1'b0;
		do_touch    = 1'b0;
		do_insert   = 1'b0;
		do_clear    = 1'b0;
		do_pin      = 1'b0;
		tgt         = '0;
		next_free_d = next_free_q;
		fault_d     = fault_q;
		case (kind_s1)
			KIND_REF: begin
				if (|pin_hit) begin
					outcome_d = OUT_PINNED_HIT;
					frame_d   = pin_idx;
				end else if (|frm_hit) begin
					outcome_d = OUT_TABLE_HIT;
					frame_d   = frm_idx;
					tgt       = frm_idx;
					do_touch  = 1'b1;
				end else if (fill_ok) begin
					outcome_d   = OUT_FREE_FILL;
					frame_d     = fill[FrameW-1:0];
					tgt         = fill[FrameW-1:0];
					do_insert   = 1'b1;
					next_free_d = fill + CountW'(1);
				end else if (victim.found) begin
					outcome_d  = OUT_REPLACED;
					frame_d    = victim.idx;
					tgt        = victim.idx;
					ev_page_d  = frame_page_q[victim.idx];
					ev_valid_d = 1'b1;
					do_touch   = 1'b1;
					if (fault_q != FaultMax) fault_d = fault_q + FaultW'(1);
				end else begin
					outcome_d = OUT_NO_FRAME;
				end
			end
			KIND_PIN: begin
				frame_d = slot_s1;
				do_pin  = 1'b1;
			end
			KIND_CLEAR: begin
				do_clear    = 1'b1;
				next_free_d = lo;
				fault_d     = '0;
			end
			default: ;
		endcase
	end

	// Rank update: a touch ages only the frames more recent than the target,
	// an insert ages every other valid frame up to the oldest rank.
	assign tgt_rank = rank_q[tgt];

	always_comb begin
		for (int i = 0; i < MaxFrames; i++) begin
			rank_d[i]        = rank_q[i];
			frame_valid_d[i] = frame_valid_q[i];
			if (do_clear) begin
				rank_d[i]        = '0;
				frame_valid_d[i] = 1'b0;
			end else if (FrameW'(i) == tgt && (do_touch || do_insert)) begin
				rank_d[i]        = '0;
				frame_valid_d[i] = 1'b1;
			end else if (frame_valid_q[i]) begin
				if (do_insert && rank_q[i] != RankMax) rank_d[i] = rank_q[i] + RankW'(1);
				if (do_touch && rank_q[i] < tgt_rank)  rank_d[i] = rank_q[i] + RankW'(1);
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind_t'(req.kind);
			slot_s1 <= req.slot;
			page_s1 <= req.page;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			outcome_s2  <= outcome_d;
			frame_s2    <= frame_d;
			ev_page_s2  <= ev_page_d;
			ev_valid_s2 <= ev_valid_d;
		end
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pinned_page_q  <= '0;
			pinned_valid_q <= '0;
			frame_valid_q  <= '0;
			rank_q         <= '0;
			next_free_q    <= '0;
			fault_q        <= '0;
		end else if (step) begin
			frame_valid_q <= frame_valid_d;
			rank_q        <= rank_d;
			next_free_q   <= next_free_d;
			fault_q       <= fault_d;
			if (do_clear) begin
				pinned_valid_q <= '0;
			end else if (do_pin) begin
				pinned_valid_q[slot_s1] <= 1'b1;
				pinned_page_q[slot_s1]  <= page_s1;
			end
		end
	end

	// Frame page contents are written on fill and on replacement only.
	always_ff @(posedge clk) begin
		if (step && (do_insert || (do_touch && ev_valid_d))) begin
			frame_page_q[tgt] <= page_s1;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.outcome       = outcome_s2;
	assign rsp.frame         = frame_s2;
	assign rsp.evicted_page  = ev_page_s2;
	assign rsp.evicted_valid = ev_valid_s2;
	assign rsp.fault_count   = fault_q;

	// A clear leaves no valid translation, frame or rank behind.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_s1 == KIND_CLEAR) |=>
			(frame_valid_q == '0 && pinned_valid_q == '0 && rank_q == '0 && fault_q == '0))
		else $error("clear left state behind");

	// The fault count only grows, except on a clear.
	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_s1 != KIND_CLEAR) |=> (fault_q >= $past(fault_q)))
		else $error("fault count went down without a clear");

	// An eviction is reported with a replacement and nothing else.
	a_evict_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ev_valid_s2) |-> (outcome_s2 == OUT_REPLACED))
		else $error("eviction reported without replacement");

	// The free pointer never runs past the table depth.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= CountMax)
		else $error("free pointer out of range");

	// A touched or filled frame comes out as the most recent one.
	a_target_mru: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (do_touch || do_insert)) |=> (rank_q[$past(tgt)] == '0 &&
			frame_valid_q[$past(tgt)]))
		else $error("target frame not made most recent");

endmodule

`default_nettype wire

// ----- test/tlb_lru_page_frame_manager_test.sv -----
// Self-checking testbench for the LRU page frame manager with pinned translations.
`default_nettype none

module tlb_lru_page_frame_manager_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlpf_pkg::*;

	// The request kind field is two bits wide, so the unused fourth code is driven as well.
	// The block must answer it with a plain setup done and change nothing.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// Watchdog limit. A correct run is about 950 beats, with drains around every register write.
	localparam int CycleLimit  = 50_000;
	// Covers the input register and the output register, plus margin.
	localparam int DrainCycles = 4;
	localparam int ReportLimit = 10;

	typedef struct {
		outcome_t          outcome;
		logic [FrameW-1:0] frame;
		page_t             evicted_page;
		logic              evicted_valid;
		logic [FaultW-1:0] fault_count;
	} frame_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;

	tlpf_req_if req_ch ();
	tlpf_rsp_if rsp_ch ();

	tlb_lru_page_frame_manager dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the block's registers and frame table, kept in step with every
	// accepted request beat and every register write.
	logic [CountW-1:0] reg_frames = FramesInUseReset;
	logic [CountW-1:0] reg_pinned = PinnedCountReset;
	page_t             pin_page   [MaxFrames] = '{default: '0};
	logic              pin_valid  [MaxFrames] = '{default: 1'b0};
	page_t             slot_page  [MaxFrames] = '{default: '0};
	logic              slot_valid [MaxFrames] = '{default: 1'b0};
	rank_t             slot_rank  [MaxFrames] = '{default: '0};
	logic [CountW-1:0] free_ptr   = '0;
	logic [FaultW-1:0] faults     = '0;

	frame_result_t pending_lookups [$];

	int tx_idle_pct;
	int rx_stall_pct;
	int error_count = 0;
	int cycle_count = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Register values above the table size behave as the table size.
	function automatic int clip_count(input logic [CountW-1:0] value);
		return (value > CountMax) ? MaxFrames : int'(value);
	endfunction

	// Move frame f to most recent; only frames that were more recent than it age by one.
	function automatic void make_recent(input int f);
		rank_t old_rank;
		old_rank = slot_rank[f];
		for (int i = 0; i < MaxFrames; i++) begin
			if (i != f && slot_valid[i] && slot_rank[i] < old_rank) begin
				slot_rank[i] = slot_rank[i] + 1'b1;
			end
		end
		slot_rank[f] = '0;
	endfunction

	// Computes the result beat of one request and updates the shadow state.
	function automatic frame_result_t lookup_frame(input logic [1:0] kind,
		input logic [FrameW-1:0] slot, input page_t page);
		frame_result_t res;
		int            lo;
		int            hi;
		int            fill;
		int            victim;
		bit            hit;
		bit            found;
		lo                = clip_count(reg_pinned);
		hi                = clip_count(reg_frames);
		res.outcome       = OUT_SETUP_DONE;
		res.frame         = '0;
		res.evicted_page  = '0;
		res.evicted_valid = 1'b0;
		hit               = 1'b0;
		found             = 1'b0;
		victim            = 0;
		case (kind)
			KIND_REF: begin
				// Pinned entries win first, lowest slot first, with no change to the ranks.
				for (int i = 0; i < lo; i++) begin
					if (!hit && pin_valid[i] && pin_page[i] == page) begin
						hit         = 1'b1;
						res.outcome = OUT_PINNED_HIT;
						res.frame   = FrameW'(i);
					end
				end
				// Only frames inside the managed window can hit.
				for (int i = lo; i < hi; i++) begin
					if (!hit && slot_valid[i] && slot_page[i] == page) begin
						hit = 1'b1;
						make_recent(i);
						res.outcome = OUT_TABLE_HIT;
						res.frame   = FrameW'(i);
					end
				end
				if (!hit) begin
					// A free pointer left below the pinned window starts at its top.
					fill = (int'(free_ptr) < lo) ? lo : int'(free_ptr);
					if (fill < hi) begin
						// A new frame comes in as most recent and every other valid frame
						// ages, saturating at the oldest rank.
						for (int i = 0; i < MaxFrames; i++) begin
							if (i != fill && slot_valid[i] && slot_rank[i] < RankMax) begin
								slot_rank[i] = slot_rank[i] + 1'b1;
							end
						end
						slot_page[fill]  = page;
						slot_valid[fill] = 1'b1;
						slot_rank[fill]  = '0;
						free_ptr         = CountW'(fill + 1);
						res.outcome      = OUT_FREE_FILL;
						res.frame        = FrameW'(fill);
					end else begin
						// The oldest valid managed frame is the victim; ties go to the
						// lowest index.
						for (int i = lo; i < hi; i++) begin
							if (slot_valid[i] && (!found || slot_rank[i] > slot_rank[victim])) begin
								victim = i;
								found  = 1'b1;
							end
						end
						if (found) begin
							res.evicted_page  = slot_page[victim];
							res.evicted_valid = 1'b1;
							slot_page[victim] = page;
							make_recent(victim);
							if (faults != FaultMax) begin
								faults = faults + 1'b1;
							end
							res.outcome = OUT_REPLACED;
							res.frame   = FrameW'(victim);
						end else begin
							res.outcome = OUT_NO_FRAME;
						end
					end
				end
			end
			KIND_PIN: begin
				pin_page[slot]  = page;
				pin_valid[slot] = 1'b1;
				res.frame       = slot;
			end
			KIND_CLEAR: begin
				// Frame page contents survive a clear, but nothing is valid any more.
				pin_valid  = '{default: 1'b0};
				slot_valid = '{default: 1'b0};
				slot_rank  = '{default: '0};
				free_ptr   = CountW'(lo);
				faults     = '0;
			end
			default: begin
			end
		endcase
		res.fault_count = faults;
		return res;
	endfunction

	// Sends one request beat, idling first at the current rate. The valid stays high on
	// return so that back-to-back beats need no second assignment in one time step.
	task automatic send_beat(input logic [1:0] kind, input logic [FrameW-1:0] slot,
		input page_t page);
		while (int'($urandom_range(99)) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.slot  <= slot;
		req_ch.page  <= page;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		pending_lookups.insert(pending_lookups.size(), lookup_frame(kind, slot, page));
	endtask

	// Holds the request side quiet until every expected beat has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAMES_IN_USE) begin
			reg_frames = value;
		end else begin
			reg_pinned = value;
		end
		@(posedge clk);
	endtask

	// Hand-picked beats through every outcome and the corner cases of the windows.
	task automatic test_directed();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		// Reset settings: sixteen frames, nothing pinned.
		send_beat(KIND_REF, 4'hF, 8'h00);
		send_beat(KIND_REF, 4'h0, 8'hFF);
		send_beat(KIND_REF, 4'h5, 8'h00);
		send_beat(KIND_PIN, 4'h0, 8'hAA);
		send_beat(KIND_PIN, 4'hF, 8'h55);
		send_beat(KIND_SPARE, 4'h7, 8'h3C);
		// Two pinned entries: page AA now answers from pinned slot 0, while page 00 in
		// frame 0 sits outside the managed window and goes to a fresh frame instead.
		write_reg(CFG_PINNED_COUNT, 5'd2);
		send_beat(KIND_REF, 4'h0, 8'hAA);
		send_beat(KIND_REF, 4'h0, 8'h00);
		// The same page in two pinned slots: the lower slot must answer.
		send_beat(KIND_PIN, 4'h1, 8'hAA);
		send_beat(KIND_REF, 4'h0, 8'hAA);
		// A pinned slot above the pinned count is not looked at.
		send_beat(KIND_REF, 4'h0, 8'h55);
		send_beat(KIND_CLEAR, 4'h0, 8'h00);
		// No managed frame at all.
		write_reg(CFG_FRAMES_IN_USE, 5'd0);
		send_beat(KIND_REF, 4'h0, 8'h12);
		// Both registers beyond the table size: everything is pinned.
		write_reg(CFG_FRAMES_IN_USE, 5'd31);
		write_reg(CFG_PINNED_COUNT, 5'd31);
		send_beat(KIND_PIN, 4'hF, 8'h77);
		send_beat(KIND_REF, 4'h0, 8'h77);
		send_beat(KIND_REF, 4'h0, 8'h78);
		// Clearing with nothing pinned parks the free pointer at 0; raising the pinned
		// count afterwards must push the next fill up to frame 3.
		write_reg(CFG_PINNED_COUNT, 5'd0);
		send_beat(KIND_CLEAR, 4'h0, 8'h00);
		write_reg(CFG_PINNED_COUNT, 5'd3);
		write_reg(CFG_FRAMES_IN_USE, 5'd5);
		send_beat(KIND_REF, 4'h0, 8'h10);
		send_beat(KIND_REF, 4'h0, 8'h11);
		send_beat(KIND_REF, 4'h0, 8'h12);
		send_beat(KIND_REF, 4'h0, 8'h11);
		// Shrinking the window leaves frame 4 valid but out of reach.
		write_reg(CFG_FRAMES_IN_USE, 5'd4);
		send_beat(KIND_REF, 4'h0, 8'h11);
		// Pinned count above the frame count: no managed frame either.
		write_reg(CFG_FRAMES_IN_USE, 5'd2);
		send_beat(KIND_REF, 4'h0, 8'h20);
	endtask

	// One phase of random traffic. Most references come from a small working set a
	// little larger than the managed window, so hits, fills and replacements all happen.
	task automatic test_random_phase(input int idle_pct, input int stall_pct,
		input logic [CountW-1:0] frames, input logic [CountW-1:0] pinned, input int beats);
		page_t pool [20];
		int    ws;
		int    roll;
		write_reg(CFG_FRAMES_IN_USE, frames);
		write_reg(CFG_PINNED_COUNT, pinned);
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		foreach (pool[i]) begin
			pool[i] = page_t'($urandom);
		end
		ws = clip_count(frames) - clip_count(pinned);
		if (ws < 1) begin
			ws = 1;
		end
		ws = (ws + 2 > 20) ? 20 : ws + 2;
		for (int n = 0; n < beats; n++) begin
			roll = int'($urandom_range(99));
			if (roll < 78) begin
				send_beat(KIND_REF, FrameW'($urandom), pool[$urandom_range(ws - 1)]);
			end else if (roll < 86) begin
				send_beat(KIND_PIN, FrameW'($urandom), pool[$urandom_range(ws - 1)]);
			end else if (roll < 89) begin
				send_beat(KIND_CLEAR, FrameW'($urandom), page_t'($urandom));
			end else if (roll < 91) begin
				send_beat(KIND_SPARE, FrameW'($urandom), page_t'($urandom));
			end else begin
				send_beat(KIND_REF, FrameW'($urandom), page_t'($urandom));
			end
		end
	endtask

	// One managed frame and a new page on every beat: each beat after the first is a
	// replacement, so the fault count climbs by one per beat.
	task automatic test_fault_count();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_reg(CFG_FRAMES_IN_USE, 5'd1);
		write_reg(CFG_PINNED_COUNT, 5'd0);
		send_beat(KIND_CLEAR, 4'h0, 8'h00);
		for (int n = 0; n < 8; n++) begin
			send_beat(KIND_REF, FrameW'(n), page_t'(n));
		end
	endtask

	// The receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		rsp_ch.ready <= (int'($urandom_range(99)) >= rx_stall_pct);
	end

	// Each result beat is checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lookups.size() == 0) begin
				error_count++;
				if (error_count <= ReportLimit) begin
					$display("unexpected result beat: outcome %0d frame %0d evicted %0d/%h faults %0d",
						rsp_ch.outcome, rsp_ch.frame, rsp_ch.evicted_valid, rsp_ch.evicted_page,
						rsp_ch.fault_count);
				end
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_ch.outcome !== want.outcome || rsp_ch.frame !== want.frame ||
					rsp_ch.evicted_page !== want.evicted_page ||
					rsp_ch.evicted_valid !== want.evicted_valid ||
					rsp_ch.fault_count !== want.fault_count) begin
					error_count++;
					if (error_count <= ReportLimit) begin
						$display("mismatch: expected outcome %0d frame %0d evicted %0d/%h faults %0d",
							want.outcome, want.frame, want.evicted_valid, want.evicted_page,
							want.fault_count);
						$display("          actual   outcome %0d frame %0d evicted %0d/%h faults %0d",
							rsp_ch.outcome, rsp_ch.frame, rsp_ch.evicted_valid, rsp_ch.evicted_page,
							rsp_ch.fault_count);
					end
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tlb_lru_page_frame_manager_test failed");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		req_ch.valid  = 1'b0;
		req_ch.kind   = '0;
		req_ch.slot   = '0;
		req_ch.page   = '0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// Idling cycles through four modes: none, sender idle, receiver stalling, both.
		// Settings run from a single frame to an oversized frame count.
		test_random_phase(0, 0, 5'd16, 5'd0, 115);
		test_random_phase(45, 0, 5'd1, 5'd0, 115);
		test_random_phase(0, 45, 5'd6, 5'd2, 115);
		test_random_phase(18, 18, 5'd31, 5'd4, 115);
		test_random_phase(0, 0, 5'd12, 5'd8, 115);
		test_random_phase(45, 0, 5'd16, 5'd13, 115);
		test_random_phase(0, 45, 5'd3, 5'd0, 115);
		test_random_phase(18, 18, 5'd9, 5'd1, 115);
		test_fault_count();

		wait_drained();
		if (error_count == 0) begin
			$display("tlb_lru_page_frame_manager_test passed");
		end else begin
			$display("tlb_lru_page_frame_manager_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
